// ----- design/hsvbs_pkg.sv -----
package hsvbs_pkg;

	// fixed field widths
	localparam int THR_BITS = 8;
	localparam int BF_BITS  = 9;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SEL_RED   = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_BLUE  = 2'd2
	} sel_t;

	// six-way hue sector
	typedef enum logic [2:0] {
		SECT_RY = 3'd0,
		SECT_YG = 3'd1,
		SECT_GC = 3'd2,
		SECT_CB = 3'd3,
		SECT_BM = 3'd4,
		SECT_MR = 3'd5
	} sector_t;

endpackage

// ----- design/hsv_brightness_scaler.sv -----
// channel     direction  transfer                    payload
// command     in         start high and busy low     red_in green_in blue_in brightness_factor
// result      out        done high, one cycle        red_out green_out blue_out
// config      in         cfg_we high                 cfg_data (grey threshold)
//
// one pixel may be started every cycle; busy is always low
// the pipeline is the hue divider, one bit per stage, plus six
// front and rebuild stages
// arst_n clears the valid bits and sets the grey threshold to 1
// results leave on done and cannot be held off, so nothing ever stalls
module hsv_brightness_scaler #(
	parameter int CHANNEL_BITS  = 8,
	parameter int HUE_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [CHANNEL_BITS-1:0]        red_in,
	input  logic [CHANNEL_BITS-1:0]        green_in,
	input  logic [CHANNEL_BITS-1:0]        blue_in,
	input  logic [hsvbs_pkg::BF_BITS-1:0]  brightness_factor,
	input  logic                           cfg_we,
	input  logic [hsvbs_pkg::THR_BITS-1:0] cfg_data,
	output logic                           done,
	output logic [CHANNEL_BITS-1:0]        red_out,
	output logic [CHANNEL_BITS-1:0]        green_out,
	output logic [CHANNEL_BITS-1:0]        blue_out
);
	import hsvbs_pkg::*;

	localparam int CB  = CHANNEL_BITS;
	localparam int FB  = HUE_FRAC_BITS;
	localparam int QB  = FB + 1;
	localparam int LAT = FB + 7;

	// side data carried through the divider
	localparam int OFS_SEL   = 2;
	localparam int OFS_BF    = 4;
	localparam int OFS_DELTA = OFS_BF + BF_BITS;
	localparam int OFS_MN    = OFS_DELTA + CB;
	localparam int OFS_MX    = OFS_MN + CB;
	localparam int SIDE_W    = OFS_MX + CB;

	// grey threshold register
	logic [THR_BITS-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_BITS'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// fully pipelined, a transfer is taken every cycle
	assign busy = 1'b0;

	logic               f_vld, f_neg, f_grey;
	logic [CB-1:0]      f_mx, f_mn, f_delta, f_diff;
	sel_t               f_sel;
	logic [BF_BITS-1:0] f_bf;

	// max, min, spread, grey decision
	hsvbs_front #(.CB(CB)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.bf       (brightness_factor),
		.thr      (thr_q),
		.vld_s1   (f_vld),
		.mx_s1    (f_mx),
		.mn_s1    (f_mn),
		.delta_s1 (f_delta),
		.diff_s1  (f_diff),
		.neg_s1   (f_neg),
		.grey_s1  (f_grey),
		.sel_s1   (f_sel),
		.bf_s1    (f_bf)
	);

	logic [SIDE_W-1:0] side_in, side_out;
	logic              d_vld, d_rem_nz;
	logic [QB-1:0]     d_quot;

	assign side_in = {f_mx, f_mn, f_delta, f_bf, f_sel, f_neg, f_grey};

	// hue fraction: diff * 2^F / delta, one bit a stage
	hsvbs_div #(.CB(CB), .QB(QB), .SIDE_W(SIDE_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (f_vld),
		.num      (f_diff),
		.den      (f_delta),
		.side_in  (side_in),
		.out_vld  (d_vld),
		.quot     (d_quot),
		.rem_nz   (d_rem_nz),
		.side_out (side_out)
	);

	// hue total, weights, brightness, sector table
	hsvbs_rebuild #(.CB(CB), .FB(FB)) u_rebuild (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (d_vld),
		.quot    (d_quot),
		.rem_nz  (d_rem_nz),
		.mx      (side_out[OFS_MX +: CB]),
		.mn      (side_out[OFS_MN +: CB]),
		.delta   (side_out[OFS_DELTA +: CB]),
		.bf      (side_out[OFS_BF +: BF_BITS]),
		.sel     (sel_t'(side_out[OFS_SEL +: 2])),
		.neg     (side_out[1]),
		.grey    (side_out[0]),
		.out_vld (done),
		.red     (red_out),
		.green   (green_out),
		.blue    (blue_out)
	);

	// every result comes from a matching earlier transfer
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transfer");

	// equal channels give a grey result
	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(red_in == green_in && green_in == blue_in, LAT))
		|-> (red_out == green_out && green_out == blue_out))
		else $error("grey pixel rebuilt with unequal channels");

	// zero brightness gives black
	a_zero_bright: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(brightness_factor == '0, LAT))
		|-> (red_out == '0 && green_out == '0 && blue_out == '0))
		else $error("zero brightness did not give black");

endmodule

// ----- design/hsvbs_front.sv -----
module hsvbs_front #(
	parameter int CB = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [CB-1:0]                 red,
	input  logic [CB-1:0]                 green,
	input  logic [CB-1:0]                 blue,
	input  logic [hsvbs_pkg::BF_BITS-1:0] bf,
	input  logic [hsvbs_pkg::THR_BITS-1:0] thr,
	output logic                          vld_s1,
	output logic [CB-1:0]                 mx_s1,
	output logic [CB-1:0]                 mn_s1,
	output logic [CB-1:0]                 delta_s1,
	output logic [CB-1:0]                 diff_s1,
	output logic                          neg_s1,
	output logic                          grey_s1,
	output hsvbs_pkg::sel_t               sel_s1,
	output logic [hsvbs_pkg::BF_BITS-1:0] bf_s1
);
	import hsvbs_pkg::*;

	localparam int CW = (CB > THR_BITS) ? CB : THR_BITS;

	logic [CB-1:0] mx, mn, delta, op_a, op_b, diff;
	logic          neg, grey;
	sel_t          sel;

	always_comb begin
		// tie rule: red only if strictly largest, then green only if above blue, else blue
		priority if (red > green && red > blue) begin
			sel  = SEL_RED;
			mx   = red;
			op_a = green;
			op_b = blue;
		end else if (green > blue) begin
			sel  = SEL_GREEN;
			mx   = green;
			op_a = blue;
			op_b = red;
		end else begin
			sel  = SEL_BLUE;
			mx   = blue;
			op_a = red;
			op_b = green;
		end
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		neg   = op_a < op_b;
		diff  = neg ? (op_b - op_a) : (op_a - op_b);
		grey  = (delta == '0) || (CW'(delta) < CW'(thr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1    <= mx;
		mn_s1    <= mn;
		delta_s1 <= delta;
		diff_s1  <= diff;
		neg_s1   <= neg;
		grey_s1  <= grey;
		sel_s1   <= sel;
		bf_s1    <= bf;
	end

endmodule

// ----- design/hsvbs_div.sv -----
module hsvbs_div #(
	parameter int CB     = 8,
	parameter int QB     = 9,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [CB-1:0]     num,
	input  logic [CB-1:0]     den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [QB-1:0]     quot,
	output logic              rem_nz,
	output logic [SIDE_W-1:0] side_out
);
	// one quotient bit per stage, restoring form; num <= den on entry

	logic              vld_s  [QB];
	logic [CB-1:0]     rem_s  [QB];
	logic [QB-1:0]     q_s    [QB];
	logic [CB-1:0]     den_s  [QB];
	logic [SIDE_W-1:0] side_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic              v_prev;
		logic [CB-1:0]     rem_prev;
		logic [QB-1:0]     q_prev;
		logic [CB-1:0]     den_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [CB:0]       trial;
		logic [CB:0]       sub;
		logic              take;

		if (i == 0) begin : g_first
			assign v_prev    = in_vld;
			assign rem_prev  = num;
			assign q_prev    = '0;
			assign den_prev  = den;
			assign side_prev = side_in;
			assign trial     = {1'b0, rem_prev};
		end else begin : g_next
			assign v_prev    = vld_s[i-1];
			assign rem_prev  = rem_s[i-1];
			assign q_prev    = q_s[i-1];
			assign den_prev  = den_s[i-1];
			assign side_prev = side_s[i-1];
			assign trial     = {rem_prev, 1'b0};
		end

		assign take = trial >= {1'b0, den_prev};
		assign sub  = trial - {1'b0, den_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= take ? sub[CB-1:0] : trial[CB-1:0];
			q_s[i]    <= {q_prev[QB-2:0], take};
			den_s[i]  <= den_prev;
			side_s[i] <= side_prev;
		end
	end

	assign out_vld  = vld_s[QB-1];
	assign quot     = q_s[QB-1];
	assign rem_nz   = |rem_s[QB-1];
	assign side_out = side_s[QB-1];

endmodule

// ----- design/hsvbs_rebuild.sv -----
module hsvbs_rebuild #(
	parameter int CB = 8,
	parameter int FB = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [FB:0]                   quot,
	input  logic                          rem_nz,
	input  logic [CB-1:0]                 mx,
	input  logic [CB-1:0]                 mn,
	input  logic [CB-1:0]                 delta,
	input  logic [hsvbs_pkg::BF_BITS-1:0] bf,
	input  hsvbs_pkg::sel_t               sel,
	input  logic                          neg,
	input  logic                          grey,
	output logic                          out_vld,
	output logic [CB-1:0]                 red,
	output logic [CB-1:0]                 green,
	output logic [CB-1:0]                 blue
);
	import hsvbs_pkg::*;

	localparam int HTW = FB + 4;
	localparam int NW  = CB + FB;
	localparam int PVW = BF_BITS + CB;
	localparam int PNW = BF_BITS + NW;

	// stage 1: hue total
	logic [HTW-1:0] base, ceil_q, ht;
	always_comb begin
		unique case (sel)
			SEL_RED:   base = neg ? (HTW'(6) << FB) : '0;
			SEL_GREEN: base = HTW'(2) << FB;
			SEL_BLUE:  base = HTW'(4) << FB;
			default:   base = '0;
		endcase
		ceil_q = HTW'(quot) + HTW'(rem_nz);
		ht     = neg ? (base - ceil_q) : (base + HTW'(quot));
	end

	logic           vld_s1, vld_s2, vld_s3, vld_s4;
	sector_t        sect_s1, sect_s2, sect_s3, sect_s4;
	logic [FB-1:0]  f_s1;
	logic [CB-1:0]  mx_s1, mx_s2, mx_s3, mn_s1, mn_s2, mn_s3, delta_s1;
	logic [BF_BITS-1:0] bf_s1, bf_s2, bf_s3;
	logic           grey_s1, grey_s2, grey_s3, grey_s4;
	logic [NW-1:0]  fd_s2, nb_s3, ng_s3;
	logic [PVW-1:0] pv_s4, pa_s4;
	logic [PNW-1:0] pb_s4, pg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			out_vld <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		sect_s1  <= sector_t'(ht[FB+2:FB]);
		f_s1     <= ht[FB-1:0];
		mx_s1    <= mx;
		mn_s1    <= mn;
		delta_s1 <= delta;
		bf_s1    <= bf;
		grey_s1  <= grey;
		// stage 2: f * delta
		fd_s2    <= NW'(f_s1) * NW'(delta_s1);
		sect_s2  <= sect_s1;
		mx_s2    <= mx_s1;
		mn_s2    <= mn_s1;
		bf_s2    <= bf_s1;
		grey_s2  <= grey_s1;
		// stage 3: beta and gamma numerators
		nb_s3    <= {mx_s2, {FB{1'b0}}} - fd_s2;
		ng_s3    <= {mn_s2, {FB{1'b0}}} + fd_s2;
		sect_s3  <= sect_s2;
		mx_s3    <= mx_s2;
		mn_s3    <= mn_s2;
		bf_s3    <= bf_s2;
		grey_s3  <= grey_s2;
		// stage 4: brightness products
		pv_s4    <= PVW'(bf_s3) * PVW'(mx_s3);
		pa_s4    <= PVW'(bf_s3) * PVW'(mn_s3);
		pb_s4    <= PNW'(bf_s3) * PNW'(nb_s3);
		pg_s4    <= PNW'(bf_s3) * PNW'(ng_s3);
		sect_s4  <= sect_s3;
		grey_s4  <= grey_s3;
	end

	// stage 5: round half up, saturate, sector table
	logic [PVW-1:0] rv, ra;
	logic [PNW-1:0] rb, rg;
	logic [CB:0]    wv, wa, wb, wg;
	logic [CB-1:0]  vv, va, vb, vg;

	always_comb begin
		rv = pv_s4 + (PVW'(1) << 7);
		ra = pa_s4 + (PVW'(1) << 7);
		rb = pb_s4 + (PNW'(1) << (7 + FB));
		rg = pg_s4 + (PNW'(1) << (7 + FB));
		wv = rv[PVW-1:8];
		wa = ra[PVW-1:8];
		wb = rb[PNW-1:8+FB];
		wg = rg[PNW-1:8+FB];
		vv = wv[CB] ? '1 : wv[CB-1:0];
		va = wa[CB] ? '1 : wa[CB-1:0];
		vb = wb[CB] ? '1 : wb[CB-1:0];
		vg = wg[CB] ? '1 : wg[CB-1:0];
	end

	always_ff @(posedge clk) begin
		if (grey_s4) begin
			red   <= vv;
			green <= vv;
			blue  <= vv;
		end else begin
			unique case (sect_s4)
				SECT_RY: begin red <= vv; green <= vg; blue <= va; end
				SECT_YG: begin red <= vb; green <= vv; blue <= va; end
				SECT_GC: begin red <= va; green <= vv; blue <= vg; end
				SECT_CB: begin red <= va; green <= vb; blue <= vv; end
				SECT_BM: begin red <= vg; green <= va; blue <= vv; end
				default: begin red <= vv; green <= va; blue <= vb; end
			endcase
		end
	end

endmodule

// ----- sim/hsv_brightness_scaler_tb.sv -----
module hsv_brightness_scaler_tb;
	import hsvbs_pkg::*;

	// fixed-point shape of the block as instantiated here
	localparam int HUE_F     = 8;
	localparam int HUE_ONE   = 1 << HUE_F;
	localparam int PIPE_WAIT = HUE_F + 7 + 8;   // pipeline depth plus margin
	localparam int PHASES    = 9;
	localparam int PER_PHASE = 172;             // random pixels per threshold setting

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// one row of the directed table: threshold in force, pixel, factor,
	// and an expected pixel where it is obvious by inspection
	typedef struct packed {
		logic [7:0] thr;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [8:0] bf;
		logic       typed;
		pixel_t     want;
	} stim_row_t;

	localparam pixel_t BLACK  = '{8'd0, 8'd0, 8'd0};
	localparam pixel_t WHITE  = '{8'd255, 8'd255, 8'd255};
	localparam pixel_t NO_EXP = '{8'd0, 8'd0, 8'd0};

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [8:0] brightness_factor;
	logic       cfg_we;
	logic [7:0] cfg_data;
	logic       done;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	// expected pixels in transfer order, oldest first
	pixel_t     pixel_q [$];
	logic [7:0] thr_now = 8'd1;   // grey threshold the block holds after reset
	int         fail_count = 0;
	int         sent_count = 0;
	int         checked_count = 0;
	int         thr_writes = 0;
	logic [7:0] thr_plan [PHASES];

	// directed rows: extremes, every hue sector, ties, grey edges
	stim_row_t dir_rows [26] = '{
		'{8'd1,   8'd0,   8'd0,   8'd0,   9'd256, 1'b1, BLACK},
		'{8'd1,   8'd255, 8'd255, 8'd255, 9'd256, 1'b1, WHITE},
		'{8'd1,   8'd255, 8'd255, 8'd255, 9'd511, 1'b1, WHITE},
		'{8'd1,   8'd255, 8'd255, 8'd255, 9'd0,   1'b1, BLACK},
		'{8'd1,   8'd128, 8'd128, 8'd128, 9'd256, 1'b1, '{8'd128, 8'd128, 8'd128}},
		'{8'd1,   8'd255, 8'd0,   8'd0,   9'd256, 1'b1, '{8'd255, 8'd0, 8'd0}},
		'{8'd1,   8'd0,   8'd255, 8'd0,   9'd256, 1'b1, '{8'd0, 8'd255, 8'd0}},
		'{8'd1,   8'd0,   8'd0,   8'd255, 9'd256, 1'b1, '{8'd0, 8'd0, 8'd255}},
		'{8'd1,   8'd255, 8'd0,   8'd0,   9'd511, 1'b1, '{8'd255, 8'd0, 8'd0}},
		'{8'd1,   8'd255, 8'd128, 8'd0,   9'd256, 1'b0, NO_EXP},
		'{8'd1,   8'd128, 8'd255, 8'd0,   9'd300, 1'b0, NO_EXP},
		'{8'd1,   8'd0,   8'd255, 8'd128, 9'd200, 1'b0, NO_EXP},
		'{8'd1,   8'd0,   8'd128, 8'd255, 9'd1,   1'b0, NO_EXP},
		'{8'd1,   8'd128, 8'd0,   8'd255, 9'd511, 1'b0, NO_EXP},
		'{8'd1,   8'd255, 8'd0,   8'd128, 9'd256, 1'b0, NO_EXP},
		'{8'd1,   8'd101, 8'd100, 8'd100, 9'd256, 1'b0, NO_EXP},
		'{8'd1,   8'd200, 8'd200, 8'd10,  9'd256, 1'b0, NO_EXP},
		'{8'd1,   8'd200, 8'd10,  8'd200, 9'd256, 1'b0, NO_EXP},
		'{8'd1,   8'd10,  8'd200, 8'd200, 9'd256, 1'b0, NO_EXP},
		'{8'd1,   8'd200, 8'd100, 8'd50,  9'd511, 1'b0, NO_EXP},
		'{8'd0,   8'd77,  8'd77,  8'd77,  9'd256, 1'b1, '{8'd77, 8'd77, 8'd77}},
		'{8'd0,   8'd0,   8'd0,   8'd0,   9'd511, 1'b1, BLACK},
		'{8'd0,   8'd100, 8'd101, 8'd100, 9'd256, 1'b0, NO_EXP},
		'{8'd255, 8'd254, 8'd0,   8'd0,   9'd256, 1'b1, '{8'd254, 8'd254, 8'd254}},
		'{8'd255, 8'd255, 8'd0,   8'd0,   9'd256, 1'b1, '{8'd255, 8'd0, 8'd0}},
		'{8'd255, 8'd10,  8'd200, 8'd90,  9'd300, 1'b0, NO_EXP}
	};

	hsv_brightness_scaler dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.red_in           (red_in),
		.green_in         (green_in),
		.blue_in          (blue_in),
		.brightness_factor(brightness_factor),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.done             (done),
		.red_out          (red_out),
		.green_out        (green_out),
		.blue_out         (blue_out)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// one rebuilt channel: V*bf*(1 - k/2^F * S), rounded half up, clipped
	function automatic logic [7:0] weigh_channel(input int bf, input int vmax,
		input int spread, input int k);
		longint acc;
		acc = longint'(bf) * (longint'(vmax) * HUE_ONE - longint'(k) * spread);
		acc = (acc + (longint'(1) << (HUE_F + 7))) >> (HUE_F + 8);
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	// brightness-scaled pixel through hsv
	function automatic pixel_t scale_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [8:0] bf, input logic [7:0] thr);
		sel_t       top;
		sector_t    sect;
		int         vmax, vmin, spread, base, diff, hue, frac;
		logic [7:0] val_w, alpha_w, beta_w, gamma_w;
		pixel_t     px;
		// red only wins when strictly largest, then green only when above blue, else blue
		if (r > g && r > b) begin
			top = SEL_RED;
			vmax = int'(r);
		end else if (g > b) begin
			top = SEL_GREEN;
			vmax = int'(g);
		end else begin
			top = SEL_BLUE;
			vmax = int'(b);
		end
		vmin = int'(r);
		if (g < vmin) vmin = int'(g);
		if (b < vmin) vmin = int'(b);
		spread = vmax - vmin;
		val_w = weigh_channel(int'(bf), vmax, spread, 0);
		// flat pixels have no hue, and zero spread never divides
		if (spread == 0 || spread < int'(thr)) begin
			px = '{val_w, val_w, val_w};
			return px;
		end
		case (top)
			SEL_RED: begin
				base = (g >= b) ? 0 : 6 * HUE_ONE;
				diff = int'(g) - int'(b);
			end
			SEL_GREEN: begin
				base = 2 * HUE_ONE;
				diff = int'(b) - int'(r);
			end
			default: begin
				base = 4 * HUE_ONE;
				diff = int'(r) - int'(g);
			end
		endcase
		// floor division, also for a negative difference
		if (diff >= 0)
			hue = base + (diff * HUE_ONE) / spread;
		else
			hue = base - ((-diff * HUE_ONE + spread - 1) / spread);
		sect = sector_t'(hue >> HUE_F);
		frac = hue & (HUE_ONE - 1);
		alpha_w = weigh_channel(int'(bf), vmax, spread, HUE_ONE);
		beta_w  = weigh_channel(int'(bf), vmax, spread, frac);
		gamma_w = weigh_channel(int'(bf), vmax, spread, HUE_ONE - frac);
		case (sect)
			SECT_RY: px = '{val_w, gamma_w, alpha_w};
			SECT_YG: px = '{beta_w, val_w, alpha_w};
			SECT_GC: px = '{alpha_w, val_w, gamma_w};
			SECT_CB: px = '{alpha_w, beta_w, val_w};
			SECT_BM: px = '{gamma_w, alpha_w, val_w};
			default: px = '{val_w, alpha_w, beta_w};
		endcase
		return px;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// present one pixel and hold it until the transfer, then log the expectation
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic [8:0] bf, input logic typed, input pixel_t want);
		start             <= 1'b1;
		red_in            <= r;
		green_in          <= g;
		blue_in           <= b;
		brightness_factor <= bf;
		@(posedge clk);
		while (busy) @(posedge clk);
		pixel_q.push_back(typed ? want : scale_pixel(r, g, b, bf, thr_now));
		sent_count++;
	endtask

	// idle cycles between pixels, with junk on the payload while start is low
	task automatic idle_gap(input bit burst);
		int n;
		n = burst ? 0 : gap_len();
		if (n > 0) begin
			start             <= 1'b0;
			red_in            <= 8'($urandom_range(0, 255));
			green_in          <= 8'($urandom_range(0, 255));
			blue_in           <= 8'($urandom_range(0, 255));
			brightness_factor <= 9'($urandom_range(0, 511));
			repeat (n) @(posedge clk);
		end
	endtask

	// stop issuing and wait for every outstanding pixel to come back
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		thr_now = v;
		thr_writes++;
	endtask

	// random pixel: uniform, spread near the threshold, tied channels or extremes
	task automatic send_random_pixel(input bit burst);
		logic [7:0] ch [3];
		logic [7:0] tmp;
		logic [8:0] bf;
		int         mode, span, lo, j;
		mode = $urandom_range(0, 9);
		if (mode < 5) begin
			for (j = 0; j < 3; j++) ch[j] = 8'($urandom_range(0, 255));
		end else if (mode < 7) begin
			// spread just around the grey threshold
			span = int'(thr_now) + int'($urandom_range(0, 4)) - 2;
			if (span < 0) span = 0;
			if (span > 255) span = 255;
			lo = $urandom_range(0, 255 - span);
			ch[0] = 8'(lo + span);
			ch[1] = 8'(lo);
			ch[2] = 8'($urandom_range(lo, lo + span));
		end else if (mode < 9) begin
			// two equal channels to hit the max tie rules
			ch[0] = 8'($urandom_range(0, 255));
			ch[1] = ch[0];
			ch[2] = 8'($urandom_range(0, 255));
		end else begin
			for (j = 0; j < 3; j++) begin
				case ($urandom_range(0, 2))
					0: ch[j] = 8'd0;
					1: ch[j] = 8'd255;
					default: ch[j] = 8'($urandom_range(0, 255));
				endcase
			end
		end
		// shuffle so any channel can carry the max
		j = $urandom_range(0, 2);
		tmp = ch[0]; ch[0] = ch[j]; ch[j] = tmp;
		j = $urandom_range(1, 2);
		tmp = ch[1]; ch[1] = ch[j]; ch[j] = tmp;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: bf = 9'($urandom_range(0, 511));
			6: begin
				case ($urandom_range(0, 2))
					0: bf = 9'd0;
					1: bf = 9'd511;
					default: bf = 9'd256;
				endcase
			end
			default: bf = 9'($urandom_range(200, 320));
		endcase
		send_pixel(ch[0], ch[1], ch[2], bf, 1'b0, NO_EXP);
		idle_gap(burst);
	endtask

	// result side: every done cycle is a transfer, checked against the oldest expectation
	always @(posedge clk) begin
		pixel_t want;
		if (done) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected result: red_out %0d green_out %0d blue_out %0d",
					red_out, green_out, blue_out);
				fail_count++;
			end else begin
				want = pixel_q.pop_front();
				checked_count++;
				if (red_out !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, red_out);
					fail_count++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, green_out);
					fail_count++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, blue_out);
					fail_count++;
				end
			end
		end
	end

	// main sequence
	initial begin
		int ph;
		bit burst;
		arst_n            = 1'b0;
		start             = 1'b0;
		red_in            = 8'd0;
		green_in          = 8'd0;
		blue_in           = 8'd0;
		brightness_factor = 9'd0;
		cfg_we            = 1'b0;
		cfg_data          = 8'd0;
		// thresholds for the random phases, both extremes included
		thr_plan[0] = 8'd0;
		thr_plan[1] = 8'd255;
		thr_plan[2] = 8'($urandom_range(0, 255));
		thr_plan[3] = 8'd2;
		thr_plan[4] = 8'($urandom_range(1, 16));
		thr_plan[5] = 8'($urandom_range(0, 255));
		thr_plan[6] = 8'd1;
		thr_plan[7] = 8'd128;
		thr_plan[8] = 8'($urandom_range(0, 64));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the first rows run on the reset threshold
		foreach (dir_rows[i]) begin
			if (dir_rows[i].thr != thr_now) begin
				drain_pipe();
				write_threshold(dir_rows[i].thr);
			end
			send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].bf,
				dir_rows[i].typed, dir_rows[i].want);
			idle_gap(1'b0);
		end

		// random phases, one threshold each; every third phase runs back to back
		for (ph = 0; ph < PHASES; ph++) begin
			drain_pipe();
			write_threshold(thr_plan[ph]);
			burst = (ph % 3 == 1);
			repeat (PER_PHASE) send_random_pixel(burst);
		end

		drain_pipe();
		repeat (PIPE_WAIT) @(posedge clk);
		$display("%0d pixels sent under %0d threshold writes, %0d results compared",
			sent_count, thr_writes, checked_count);
		if (fail_count == 0 && pixel_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
design/hsvbs_pkg.sv
design/hsvbs_front.sv
design/hsvbs_div.sv
design/hsvbs_rebuild.sv
design/hsv_brightness_scaler.sv
sim/hsv_brightness_scaler_tb.sv
